/* design/ipthe_pkg.sv */
// shared types, constants and helper functions for the ip/tcp header extractor
package ipthe_pkg;

	localparam int unsigned OFF_W = 7;
	localparam logic [OFF_W-1:0] OFF_MAX = 7'd127;

	localparam logic [3:0] VER_IPV4 = 4'd4;
	localparam logic [3:0] VER_IPV6 = 4'd6;
	localparam logic [7:0] PROTO_TCP = 8'd6;
	localparam logic [5:0] IPV6_HDR_LEN = 6'd40;
	localparam logic [6:0] IPV4_MIN_NEED = 7'd20;
	localparam logic [6:0] IPV6_MIN_NEED = 7'd40;
	localparam logic [6:0] OTHER_NEED = 7'd1;

	localparam logic [1:0] KIND_NONE = 2'd0;
	localparam logic [1:0] KIND_IPV4 = 2'd1;
	localparam logic [1:0] KIND_IPV6 = 2'd2;

	// capture state of the packet in flight
	typedef struct packed {
		logic [OFF_W-1:0] offset;
		logic [3:0]       version;
		logic [3:0]       ihl;
		logic [7:0]       proto;
		logic [63:0]      src_hi;
		logic [63:0]      src_lo;
		logic [63:0]      dst_hi;
		logic [63:0]      dst_lo;
		logic [15:0]      sport;
		logic [15:0]      dport;
		logic [5:0]       flags;
	} fields_t;

	// one result transfer
	typedef struct packed {
		logic [1:0]  ip_kind;
		logic [5:0]  header_len;
		logic [63:0] src_addr_high;
		logic [63:0] src_addr_low;
		logic [63:0] dst_addr_high;
		logic [63:0] dst_addr_low;
		logic [15:0] src_port;
		logic [15:0] dst_port;
		logic        is_tcp;
		logic [5:0]  tcp_flags;
		logic        truncated;
	} result_t;

	// transport header offset: ihl*4 for ipv4, 40 for ipv6, else zero
	function automatic logic [5:0] hdr_bytes(input logic [3:0] ver, input logic [3:0] ihl);
		logic [5:0] res;
		if (ver == VER_IPV4) begin
			res = {ihl, 2'b00};
		end else if (ver == VER_IPV6) begin
			res = IPV6_HDR_LEN;
		end else begin
			res = '0;
		end
		return res;
	endfunction

	// place a byte at big-endian lane pos of a 64-bit word
	function automatic logic [63:0] put_lane(input logic [63:0] word, input logic [2:0] pos,
			input logic [7:0] b);
		logic [63:0] res;
		res = word;
		res[{~pos, 3'b000} +: 8] = b;
		return res;
	endfunction

endpackage

/* design/ipthe_if.sv */
// channel interfaces: packet byte stream in, header result out
interface ipthe_in_if;
	logic       valid;
	logic       ready;
	logic [7:0] data_byte;
	logic       last_byte;

	modport source(output valid, output data_byte, output last_byte, input ready);
	modport sink(input valid, input data_byte, input last_byte, output ready);
endinterface

interface ipthe_out_if;
	logic        valid;
	logic        ready;
	logic [1:0]  ip_kind;
	logic [5:0]  header_len;
	logic [63:0] src_addr_high;
	logic [63:0] src_addr_low;
	logic [63:0] dst_addr_high;
	logic [63:0] dst_addr_low;
	logic [15:0] src_port;
	logic [15:0] dst_port;
	logic        is_tcp;
	logic [5:0]  tcp_flags;
	logic        truncated;

	modport source(output valid, output ip_kind, output header_len, output src_addr_high,
		output src_addr_low, output dst_addr_high, output dst_addr_low, output src_port,
		output dst_port, output is_tcp, output tcp_flags, output truncated, input ready);
	modport sink(input valid, input ip_kind, input header_len, input src_addr_high,
		input src_addr_low, input dst_addr_high, input dst_addr_low, input src_port,
		input dst_port, input is_tcp, input tcp_flags, input truncated, output ready);
endinterface

/* design/ip_tcp_header_extractor.sv */
// top level of the ip/tcp header extractor
//
//   channel | dir | payload                                   | transfer when
//   --------+-----+-------------------------------------------+----------------------
//   pkt     | in  | data_byte, last_byte                      | pkt.valid & pkt.ready
//   hdr     | out | ip_kind .. truncated (one per packet)     | hdr.valid & hdr.ready
//
// one byte per clock unless hdr stalls on a last byte; bytes pass the input register, and
// the result for a packet shows on hdr the cycle after its last byte leaves that register
// hdr.valid is set once the last byte leaves the input register and loads the output register
// reset clears the byte offset, all capture fields and both valid flags
// a stalled hdr holds only the last byte of the next packet; earlier bytes keep flowing
module ip_tcp_header_extractor (
	input  logic         clk,
	input  logic         arst_n,
	ipthe_in_if.sink     pkt,
	ipthe_out_if.source  hdr
);
	import ipthe_pkg::*;

	// input register stage
	logic [7:0] data_s1;
	logic       last_s1;
	logic       valid_s1;

	logic       advance;
	logic       can_load;
	fields_t    cur_fields;

	// a last byte may only move on once the output register is free
	assign advance = valid_s1 && (!last_s1 || can_load);
	assign pkt.ready = !valid_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (pkt.valid && pkt.ready) begin
			valid_s1 <= 1'b1;
		end else if (advance) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (pkt.valid && pkt.ready) begin
			data_s1 <= pkt.data_byte;
			last_s1 <= pkt.last_byte;
		end
	end

	// offset tracking and capture of every field
	ipthe_capture u_capture (
		.clk        (clk),
		.arst_n     (arst_n),
		.adv        (advance),
		.data_in    (data_s1),
		.last_in    (last_s1),
		.cur_fields (cur_fields)
	);

	// result formatting and output register
	ipthe_result u_result (
		.clk      (clk),
		.arst_n   (arst_n),
		.load     (advance && last_s1),
		.f        (cur_fields),
		.can_load (can_load),
		.hdr      (hdr)
	);

	// a new result only follows a last byte moving through
	a_result_source: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(hdr.valid) |-> $past(advance && last_s1))
		else $error("result without a last byte");
	// a held byte keeps its contents
	a_stage_hold: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s1 && !advance |=> valid_s1 && $stable(data_s1) && $stable(last_s1))
		else $error("input stage lost a held byte");
	// only a last byte can be held back
	a_hold_last_only: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s1 && !advance |-> last_s1 && hdr.valid)
		else $error("non-last byte stalled");

endmodule

/* design/ipthe_capture.sv */
// byte offset tracking and field capture registers
module ipthe_capture (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              adv,
	input  logic [7:0]        data_in,
	input  logic              last_in,
	output ipthe_pkg::fields_t cur_fields
);
	import ipthe_pkg::*;

	fields_t fields_q;
	fields_t f;
	fields_t f_next;

	always_comb begin
		logic [OFF_W-1:0] off;
		logic [7:0]       off8;
		logic [7:0]       t8;
		logic             v4;
		logic             v6;
		f = fields_q;
		off = fields_q.offset;
		off8 = {1'b0, off};
		if (off == '0) begin
			f.version = data_in[7:4];
			f.ihl = data_in[3:0];
		end
		v4 = (f.version == VER_IPV4);
		v6 = (f.version == VER_IPV6);
		t8 = {2'b00, hdr_bytes(f.version, f.ihl)};
		if (v4) begin
			if (off == 7'd9) f.proto = data_in;
			if (off inside {[7'd12:7'd15]}) f.src_lo = put_lane(f.src_lo, 3'(off - 7'd8), data_in);
			if (off inside {[7'd16:7'd19]}) f.dst_lo = put_lane(f.dst_lo, 3'(off - 7'd12), data_in);
		end else if (v6) begin
			if (off == 7'd6) f.proto = data_in;
			if (off inside {[7'd8:7'd15]}) f.src_hi = put_lane(f.src_hi, off[2:0], data_in);
			if (off inside {[7'd16:7'd23]}) f.src_lo = put_lane(f.src_lo, off[2:0], data_in);
			if (off inside {[7'd24:7'd31]}) f.dst_hi = put_lane(f.dst_hi, off[2:0], data_in);
			if (off inside {[7'd32:7'd39]}) f.dst_lo = put_lane(f.dst_lo, off[2:0], data_in);
		end
		// transport bytes; with a tiny ihl these can overlap ip header bytes
		if (v4 || v6) begin
			if (off8 == t8) f.sport[15:8] = data_in;
			if (off8 == t8 + 8'd1) f.sport[7:0] = data_in;
			if (off8 == t8 + 8'd2) f.dport[15:8] = data_in;
			if (off8 == t8 + 8'd3) f.dport[7:0] = data_in;
			if (off8 == t8 + 8'd13) f.flags = data_in[5:0];
		end
	end

	assign cur_fields = f;

	// captured fields with the offset stepped, saturating at the top
	always_comb begin
		f_next = f;
		f_next.offset = (fields_q.offset == OFF_MAX) ? OFF_MAX : fields_q.offset + 7'd1;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fields_q <= '0;
		end else if (adv) begin
			if (last_in) begin
				fields_q <= '0;
			end else begin
				fields_q <= f_next;
			end
		end
	end

	a_clear_after_last: assert property (@(posedge clk) disable iff (!arst_n)
		adv && last_in |=> fields_q.offset == '0 && fields_q.version == '0)
		else $error("capture state not cleared after last byte");
	a_hold_when_idle: assert property (@(posedge clk) disable iff (!arst_n)
		!adv |=> $stable(fields_q))
		else $error("capture state changed without a byte");
	a_offset_step: assert property (@(posedge clk) disable iff (!arst_n)
		adv && !last_in && fields_q.offset != OFF_MAX |=>
			fields_q.offset == $past(fields_q.offset) + 7'd1)
		else $error("byte offset did not advance");

endmodule

/* design/ipthe_result.sv */
// result formatting, truncation check and output register
module ipthe_result (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               load,
	input  ipthe_pkg::fields_t f,
	output logic               can_load,
	ipthe_out_if.source        hdr
);
	import ipthe_pkg::*;

	result_t res_q;
	result_t r;
	logic    valid_q;

	always_comb begin
		logic       v4;
		logic       v6;
		logic       tcp;
		logic [5:0] t;
		logic [6:0] need;
		logic [7:0] count;
		v4 = (f.version == VER_IPV4);
		v6 = (f.version == VER_IPV6);
		tcp = (v4 || v6) && (f.proto == PROTO_TCP);
		t = hdr_bytes(f.version, f.ihl);
		need = OTHER_NEED;
		if (v4 || v6) begin
			need = v4 ? IPV4_MIN_NEED : IPV6_MIN_NEED;
			if ({1'b0, t} + 7'd4 > need) need = {1'b0, t} + 7'd4;
			if (tcp && ({1'b0, t} + 7'd14 > need)) need = {1'b0, t} + 7'd14;
		end
		count = {1'b0, f.offset} + 8'd1;
		r.ip_kind = v4 ? KIND_IPV4 : (v6 ? KIND_IPV6 : KIND_NONE);
		r.header_len = t;
		r.src_addr_high = f.src_hi;
		r.src_addr_low = f.src_lo;
		r.dst_addr_high = f.dst_hi;
		r.dst_addr_low = f.dst_lo;
		r.src_port = (v4 || v6) ? f.sport : '0;
		r.dst_port = (v4 || v6) ? f.dport : '0;
		r.is_tcp = tcp;
		r.tcp_flags = tcp ? f.flags : '0;
		r.truncated = (count < {1'b0, need});
	end

	assign can_load = !valid_q || hdr.ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (load) begin
			valid_q <= 1'b1;
		end else if (hdr.ready) begin
			valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			res_q <= r;
		end
	end

	assign hdr.valid = valid_q;
	assign hdr.ip_kind = res_q.ip_kind;
	assign hdr.header_len = res_q.header_len;
	assign hdr.src_addr_high = res_q.src_addr_high;
	assign hdr.src_addr_low = res_q.src_addr_low;
	assign hdr.dst_addr_high = res_q.dst_addr_high;
	assign hdr.dst_addr_low = res_q.dst_addr_low;
	assign hdr.src_port = res_q.src_port;
	assign hdr.dst_port = res_q.dst_port;
	assign hdr.is_tcp = res_q.is_tcp;
	assign hdr.tcp_flags = res_q.tcp_flags;
	assign hdr.truncated = res_q.truncated;

	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		load |-> can_load)
		else $error("result loaded over a pending transfer");
	a_trunc_kind: assert property (@(posedge clk) disable iff (!arst_n)
		hdr.valid && hdr.truncated |-> hdr.ip_kind != KIND_NONE)
		else $error("truncated set for unknown version");
	a_flags_tcp: assert property (@(posedge clk) disable iff (!arst_n)
		hdr.valid && !hdr.is_tcp |-> hdr.tcp_flags == '0)
		else $error("tcp flags set on non-tcp packet");

endmodule
